// ===== rtl/ascii_to_morse_keyer_assert.svh =====
// assertion macros shared by the keyer modules
`ifndef ASCII_TO_MORSE_KEYER_ASSERT_SVH
`define ASCII_TO_MORSE_KEYER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define A2M_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keyer check failed");
// next-cycle implication, checked out of reset
`define A2M_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keyer check failed");
`else
`define A2M_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define A2M_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/a2m_pkg.sv =====
// shared types, constants and the morse pattern rom for the keyer
`default_nettype none
package a2m_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_DIT        = 3'd0;
	localparam logic [2:0] CFG_DAH        = 3'd1;
	localparam logic [2:0] CFG_GAP        = 3'd2;
	localparam logic [2:0] CFG_CHAR_SPACE = 3'd3;
	localparam logic [2:0] CFG_WORD_SPACE = 3'd4;
	localparam logic [2:0] CFG_WORD_CRED  = 3'd5;

	// register reset values
	localparam logic [7:0] RST_DIT        = 8'd1;
	localparam logic [7:0] RST_DAH        = 8'd3;
	localparam logic [7:0] RST_GAP        = 8'd1;
	localparam logic [7:0] RST_CHAR_SPACE = 8'd3;
	localparam logic [7:0] RST_WORD_SPACE = 8'd7;
	localparam logic [7:0] RST_WORD_CRED  = 8'd1;

	// character classes
	localparam logic [1:0] KIND_BAD   = 2'd0;
	localparam logic [1:0] KIND_CHAR  = 2'd1;
	localparam logic [1:0] KIND_SPACE = 2'd2;

	// ascii landmarks
	localparam logic [7:0] ASC_UPPER_A = 8'h41;
	localparam logic [7:0] ASC_UPPER_Z = 8'h5a;
	localparam logic [7:0] ASC_LOWER_A = 8'h61;
	localparam logic [7:0] ASC_LOWER_Z = 8'h7a;
	localparam logic [7:0] ASC_SPACE   = 8'h20;
	localparam logic [7:0] ASC_ZERO    = 8'h30;
	localparam logic [7:0] ASC_NINE    = 8'h39;
	localparam logic [7:0] UPPER_BIAS  = 8'd55;
	localparam logic [7:0] LOWER_BIAS  = 8'd87;

	// command and status between sequencer and datapath
	typedef struct packed {
		logic load;
		logic emit;
	} a2m_cmd_t;

	typedef struct packed {
		logic seg_last;
		logic out_free;
	} a2m_sts_t;

	// pattern rom: length in bits 7..5, element i is a dah when bit i is set
	function automatic logic [7:0] a2m_rom(input logic [5:0] slot);
		logic [7:0] r;
		case (slot)
			6'd0:  r = 8'hbf;
			6'd1:  r = 8'hbe;
			6'd2:  r = 8'hbc;
			6'd3:  r = 8'hb8;
			6'd4:  r = 8'hb0;
			6'd5:  r = 8'ha0;
			6'd6:  r = 8'ha1;
			6'd7:  r = 8'ha3;
			6'd8:  r = 8'ha7;
			6'd9:  r = 8'haf;
			6'd10: r = 8'h42;
			6'd11: r = 8'h81;
			6'd12: r = 8'h85;
			6'd13: r = 8'h61;
			6'd14: r = 8'h20;
			6'd15: r = 8'h84;
			6'd16: r = 8'h63;
			6'd17: r = 8'h80;
			6'd18: r = 8'h40;
			6'd19: r = 8'h8e;
			6'd20: r = 8'h65;
			6'd21: r = 8'h82;
			6'd22: r = 8'h43;
			6'd23: r = 8'h41;
			6'd24: r = 8'h67;
			6'd25: r = 8'h86;
			6'd26: r = 8'h8b;
			6'd27: r = 8'h62;
			6'd28: r = 8'h60;
			6'd29: r = 8'h21;
			6'd30: r = 8'h64;
			6'd31: r = 8'h88;
			6'd32: r = 8'h66;
			6'd33: r = 8'h89;
			6'd34: r = 8'h8d;
			6'd35: r = 8'h83;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// silence still owed once the credit is taken off
	function automatic logic [7:0] a2m_top_up(input logic [7:0] target,
		input logic [7:0] credit);
		return (credit < target) ? (target - credit) : 8'd0;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/a2m_ctrl.sv =====
// sequencer for the keyer: accepts a character, then steps out its segments
`default_nettype none
`include "ascii_to_morse_keyer_assert.svh"
module a2m_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_stall,
	input  a2m_pkg::a2m_sts_t sts,
	output a2m_pkg::a2m_cmd_t cmd
);
	import a2m_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EMIT = 1'b1;

	logic state_q;

	// handshake and commands
	always_comb begin
		in_stall = (state_q != S_IDLE);
		cmd.load = in_valid && (state_q == S_IDLE);
		cmd.emit = (state_q == S_EMIT) && sts.out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (cmd.emit && sts.seg_last) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`A2M_ASSERT_NEXT(a_load_starts, clk, arst_n, cmd.load, state_q == S_EMIT)
	`A2M_ASSERT_NEXT(a_last_ends, clk, arst_n, cmd.emit && sts.seg_last, state_q == S_IDLE)
	`A2M_ASSERT_NEXT(a_stall_holds, clk, arst_n, (state_q == S_EMIT) && !sts.out_free,
		state_q == S_EMIT)

endmodule
`default_nettype wire

// ===== rtl/a2m_dp.sv =====
// keyer datapath: registers, rom decode, segment builder and output word register
`default_nettype none
`include "ascii_to_morse_keyer_assert.svh"
module a2m_dp (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_we,
	input  wire  [2:0]        cfg_index,
	input  wire  [7:0]        cfg_data,
	input  wire  [7:0]        ascii_code,
	input  a2m_pkg::a2m_cmd_t cmd,
	output a2m_pkg::a2m_sts_t sts,
	output logic              out_valid,
	input  wire               out_stall,
	output logic              key_on,
	output logic [7:0]        duration,
	output logic              last,
	output logic              char_valid,
	output logic [11:0]       total_ticks
);
	import a2m_pkg::*;

	logic [7:0]  dit_q, dah_q, gap_q, cspace_q, wspace_q, wcred_q;
	logic [1:0]  kind_q;
	logic [4:0]  pat_q;
	logic [2:0]  len_q;
	logic [2:0]  cnt_q;
	logic        phase_q;
	logic [11:0] total_q;
	logic        out_valid_q;

	logic [1:0]  dec_kind;
	logic [5:0]  dec_slot;
	logic [7:0]  dec_rom;
	logic        seg_key, seg_last, seg_valid;
	logic [7:0]  seg_dur;
	logic [11:0] seg_total;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dit_q    <= RST_DIT;
			dah_q    <= RST_DAH;
			gap_q    <= RST_GAP;
			cspace_q <= RST_CHAR_SPACE;
			wspace_q <= RST_WORD_SPACE;
			wcred_q  <= RST_WORD_CRED;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIT:        dit_q    <= cfg_data;
				CFG_DAH:        dah_q    <= cfg_data;
				CFG_GAP:        gap_q    <= cfg_data;
				CFG_CHAR_SPACE: cspace_q <= cfg_data;
				CFG_WORD_SPACE: wspace_q <= cfg_data;
				CFG_WORD_CRED:  wcred_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify the byte and find its rom slot
	always_comb begin
		dec_kind = KIND_BAD;
		dec_slot = 6'd0;
		if (ascii_code inside {[ASC_UPPER_A:ASC_UPPER_Z]}) begin
			dec_kind = KIND_CHAR;
			dec_slot = 6'(ascii_code - UPPER_BIAS);
		end else if (ascii_code inside {[ASC_LOWER_A:ASC_LOWER_Z]}) begin
			dec_kind = KIND_CHAR;
			dec_slot = 6'(ascii_code - LOWER_BIAS);
		end else if (ascii_code inside {[ASC_ZERO:ASC_NINE]}) begin
			dec_kind = KIND_CHAR;
			dec_slot = 6'(ascii_code - ASC_ZERO);
		end else if (ascii_code == ASC_SPACE) begin
			dec_kind = KIND_SPACE;
		end
		dec_rom = a2m_rom(dec_slot);
	end

	// build the current segment
	always_comb begin
		seg_key   = 1'b0;
		seg_dur   = 8'd0;
		seg_last  = 1'b1;
		seg_valid = 1'b1;
		seg_total = 12'd0;
		case (kind_q)
			KIND_CHAR: begin
				if (cnt_q != len_q) begin
					seg_last = 1'b0;
					if (!phase_q) begin
						seg_key = 1'b1;
						seg_dur = pat_q[cnt_q] ? dah_q : dit_q;
					end else begin
						seg_dur = gap_q;
					end
				end else begin
					seg_dur   = a2m_top_up(cspace_q, gap_q);
					seg_total = total_q + {4'd0, seg_dur};
				end
			end
			KIND_SPACE: begin
				seg_dur   = a2m_top_up(wspace_q, wcred_q);
				seg_total = {4'd0, seg_dur};
			end
			default: begin
				seg_valid = 1'b0;
			end
		endcase
	end

	// per-character sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_BAD;
			pat_q   <= 5'd0;
			len_q   <= 3'd0;
			cnt_q   <= 3'd0;
			phase_q <= 1'b0;
			total_q <= 12'd0;
		end else if (cmd.load) begin
			kind_q  <= dec_kind;
			pat_q   <= dec_rom[4:0];
			len_q   <= dec_rom[7:5];
			cnt_q   <= 3'd0;
			phase_q <= 1'b0;
			total_q <= 12'd0;
		end else if (cmd.emit) begin
			total_q <= total_q + {4'd0, seg_dur};
			if ((kind_q == KIND_CHAR) && (cnt_q != len_q)) begin
				phase_q <= ~phase_q;
				if (phase_q) cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	// output word register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			key_on      <= seg_key;
			duration    <= seg_dur;
			last        <= seg_last;
			char_valid  <= seg_valid;
			total_ticks <= seg_total;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.seg_last = seg_last;

	`A2M_ASSERT_IMPL(a_cnt_bound, clk, arst_n, kind_q == KIND_CHAR, cnt_q <= len_q)
	`A2M_ASSERT_NEXT(a_last_word, clk, arst_n, cmd.emit && seg_last, out_valid_q && last)
	`A2M_ASSERT_NEXT(a_mid_total, clk, arst_n, cmd.emit && !seg_last, total_ticks == 12'd0)

endmodule
`default_nettype wire

// ===== rtl/ascii_to_morse_keyer.sv =====
// top level of the ascii to morse keyer
// Usage:
// The input channel (in_valid, in_stall, ascii_code) takes one character byte
// per word. The output channel (out_valid, out_stall and the segment fields)
// gives the keying of that character as a run of segments: key level,
// duration in ticks, a last flag, char_valid and, on the last segment, the
// character's total ticks.
// The byte is registered into the sequencing state when taken, and the first
// segment is then loaded into the output register once that is free. A letter
// or digit of n elements gives 2n+1 segments, a space or an unsupported byte
// gives one; with no stall one segment leaves per cycle. The segment sequencer
// handles one character at a time.
// in_stall rises once a byte is taken and falls when its last segment has been
// loaded into the output register, so the next byte can be taken while that
// segment still waits. A stall on the output holds the word and the sequencer.
// Reset clears the sequencer and loads the timing registers with their defaults
// (dit 1, dah 3, gap 1, char space 3, word space 7, word credit 1). The user
// writes timing registers via cfg_we/cfg_index/cfg_data while idle; unenforced.
`default_nettype none
module ascii_to_morse_keyer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [7:0]  cfg_data,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  ascii_code,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        key_on,
	output logic [7:0]  duration,
	output logic        last,
	output logic        char_valid,
	output logic [11:0] total_ticks
);
	import a2m_pkg::*;

	a2m_cmd_t cmd;
	a2m_sts_t sts;

	// sequencer
	a2m_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	a2m_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.ascii_code  (ascii_code),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.key_on      (key_on),
		.duration    (duration),
		.last        (last),
		.char_valid  (char_valid),
		.total_ticks (total_ticks)
	);

endmodule
`default_nettype wire

// ===== tb/keyer_checker.sv =====
// segment predictor and checker for the ascii to morse keyer
`timescale 1ns / 1ps
module keyer_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [7:0]  cfg_data,
	input  wire         in_valid,
	input  wire         in_stall,
	input  wire  [7:0]  ascii_code,
	input  wire         out_valid,
	input  wire         out_stall,
	input  wire         key_on,
	input  wire  [7:0]  duration,
	input  wire         last,
	input  wire         char_valid,
	input  wire  [11:0] total_ticks,
	output int          pending,
	output int          failures
);
	import a2m_pkg::*;

	typedef struct packed {
		logic        key;
		logic [7:0]  dur;
		logic        fin;
		logic        ok;
		logic [11:0] total;
	} keying_seg_t;

	// shadow copy of the timing registers
	logic [7:0] dit_len, dah_len, gap_len, char_gap, word_gap, word_credit;

	keying_seg_t expected_segs[$];

	// dots and dashes of one upper-case letter or digit, empty if none
	function automatic string morse_of(input logic [7:0] ch);
		case (ch)
			"A": return ".-";
			"B": return "-...";
			"C": return "-.-.";
			"D": return "-..";
			"E": return ".";
			"F": return "..-.";
			"G": return "--.";
			"H": return "....";
			"I": return "..";
			"J": return ".---";
			"K": return "-.-";
			"L": return ".-..";
			"M": return "--";
			"N": return "-.";
			"O": return "---";
			"P": return ".--.";
			"Q": return "--.-";
			"R": return ".-.";
			"S": return "...";
			"T": return "-";
			"U": return "..-";
			"V": return "...-";
			"W": return ".--";
			"X": return "-..-";
			"Y": return "-.--";
			"Z": return "--..";
			"0": return "-----";
			"1": return ".----";
			"2": return "..---";
			"3": return "...--";
			"4": return "....-";
			"5": return ".....";
			"6": return "-....";
			"7": return "--...";
			"8": return "---..";
			"9": return "----.";
			default: return "";
		endcase
	endfunction

	// silence owed after the credit is taken off, never below zero
	function automatic logic [7:0] owed_silence(input logic [7:0] target,
		input logic [7:0] credit);
		return (credit < target) ? target - credit : 8'd0;
	endfunction

	// queue every segment the keyer should send for one character word
	function automatic void queue_keying(input logic [7:0] ch);
		string       elems;
		keying_seg_t seg;
		int          sum;
		logic [7:0]  up;
		up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
		elems = morse_of(up);
		seg.ok = 1'b1;
		seg.key = 1'b0;
		seg.fin = 1'b0;
		seg.total = '0;
		if (ch == " ") begin
			seg.dur = owed_silence(word_gap, word_credit);
			seg.fin = 1'b1;
			seg.total = {4'd0, seg.dur};
			expected_segs.push_back(seg);
		end else if (elems.len() == 0) begin
			seg.dur = 8'd0;
			seg.fin = 1'b1;
			seg.ok = 1'b0;
			expected_segs.push_back(seg);
		end else begin
			sum = 0;
			for (int i = 0; i < elems.len(); i++) begin
				seg.key = 1'b1;
				seg.dur = (elems[i] == "-") ? dah_len : dit_len;
				sum += seg.dur;
				expected_segs.push_back(seg);
				seg.key = 1'b0;
				seg.dur = gap_len;
				sum += seg.dur;
				expected_segs.push_back(seg);
			end
			seg.dur = owed_silence(char_gap, gap_len);
			sum += seg.dur;
			seg.fin = 1'b1;
			seg.total = sum[11:0];
			expected_segs.push_back(seg);
		end
	endfunction

	// watch register writes, accepted bytes and accepted segments
	always @(posedge clk or negedge arst_n) begin
		keying_seg_t want;
		if (!arst_n) begin
			dit_len = RST_DIT;
			dah_len = RST_DAH;
			gap_len = RST_GAP;
			char_gap = RST_CHAR_SPACE;
			word_gap = RST_WORD_SPACE;
			word_credit = RST_WORD_CRED;
			expected_segs.delete();
			failures = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DIT:        dit_len = cfg_data;
					CFG_DAH:        dah_len = cfg_data;
					CFG_GAP:        gap_len = cfg_data;
					CFG_CHAR_SPACE: char_gap = cfg_data;
					CFG_WORD_SPACE: word_gap = cfg_data;
					CFG_WORD_CRED:  word_credit = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				queue_keying(ascii_code);
			if (out_valid && !out_stall) begin
				if (expected_segs.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected segment: key %0d dur %0d last %0d %s %0d %s %0d",
							key_on, duration, last, "valid", char_valid,
							"total", total_ticks);
				end else begin
					want = expected_segs.pop_front();
					if (key_on !== want.key || duration !== want.dur || last !== want.fin ||
						char_valid !== want.ok || total_ticks !== want.total) begin
						failures++;
						if (failures <= 10) begin
							$display("segment mismatch at %0t", $realtime);
							$display("  expected key %0d dur %0d last %0d valid %0d total %0d",
								want.key, want.dur, want.fin, want.ok, want.total);
							$display("  got key %0d dur %0d last %0d valid %0d total %0d",
								key_on, duration, last, char_valid, total_ticks);
						end
					end
				end
			end
			pending = expected_segs.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// top of the keyer testbench: clock, reset, character stimulus and verdict
`timescale 1ns / 1ps
module testbench;
	import a2m_pkg::*;

	localparam int          CYCLE_LIMIT  = 200000;
	localparam logic [2:0]  CFG_SPARE    = CFG_WORD_CRED + 3'd1;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  ascii_code;
	logic        out_valid;
	logic        out_stall;
	logic        key_on;
	logic [7:0]  duration;
	logic        last;
	logic        char_valid;
	logic [11:0] total_ticks;
	int          pending;
	int          failures;
	int          cycles;
	int          hold;
	bit          quiet;

	ascii_to_morse_keyer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .ascii_code(ascii_code),
		.out_valid(out_valid), .out_stall(out_stall),
		.key_on(key_on), .duration(duration), .last(last),
		.char_valid(char_valid), .total_ticks(total_ticks)
	);

	keyer_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .ascii_code(ascii_code),
		.out_valid(out_valid), .out_stall(out_stall),
		.key_on(key_on), .duration(duration), .last(last),
		.char_valid(char_valid), .total_ticks(total_ticks),
		.pending(pending), .failures(failures)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// segment receiver stalls at random before taking each word
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 4);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			@(negedge clk);
		end
	end

	// offer one character word after a random gap and hold it until taken
	task automatic send_char(input logic [7:0] ch);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		ascii_code <= ch;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// drop valid and wait until every predicted segment has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	// rewrite all timing registers, plus a write to an unused index
	task automatic program_timing(input logic [7:0] dit, dah, gap, cs, ws, wc);
		put_reg(CFG_DIT, dit);
		put_reg(CFG_DAH, dah);
		put_reg(CFG_GAP, gap);
		put_reg(CFG_CHAR_SPACE, cs);
		put_reg(CFG_WORD_SPACE, ws);
		put_reg(CFG_WORD_CRED, wc);
		put_reg(CFG_SPARE + 3'($urandom_range(0, 1)), 8'($urandom));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// mostly letters, digits and spaces, with some arbitrary bytes
	task automatic random_chars(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			quiet = (i < 8);
			pick = $urandom_range(0, 99);
			if (pick < 40)
				send_char(ASC_UPPER_A + 8'($urandom_range(0, 25)));
			else if (pick < 60)
				send_char(ASC_LOWER_A + 8'($urandom_range(0, 25)));
			else if (pick < 75)
				send_char(ASC_ZERO + 8'($urandom_range(0, 9)));
			else if (pick < 87)
				send_char(ASC_SPACE);
			else
				send_char(8'($urandom_range(0, 255)));
		end
		quiet = 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		logic [7:0] edge_chars[$];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		ascii_code = '0;
		quiet = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// class boundaries and shortest/longest patterns at reset timing
		edge_chars = '{"A", "Z", "a", "z", "0", "9", " ", "E", "T", "5", "q",
			8'h00, 8'hff, 8'h40, 8'h5b, 8'h60, 8'h7b, 8'h2f, 8'h3a, 8'h1f,
			8'h21, 8'h80, 8'h7f, 8'h55};
		foreach (edge_chars[i]) send_char(edge_chars[i]);
		random_chars(20);
		drain();

		// long elements, fully covered char and word space
		program_timing(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255);
		send_char(" ");
		send_char("0");
		random_chars(20);
		drain();

		// zero-length elements and gaps, widest top-ups
		program_timing(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0);
		send_char(" ");
		send_char("8");
		random_chars(20);
		drain();

		// credit equal to target on both top-ups
		program_timing(8'd1, 8'd255, 8'd37, 8'd37, 8'd200, 8'd200);
		random_chars(15);
		drain();

		// arbitrary timing
		repeat (3) begin
			program_timing(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom));
			random_chars(15);
			drain();
		end

		repeat (20) @(negedge clk);
		if (failures == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== ascii_to_morse_keyer.f =====
+incdir+rtl
rtl/a2m_pkg.sv
rtl/a2m_ctrl.sv
rtl/a2m_dp.sv
rtl/ascii_to_morse_keyer.sv
tb/keyer_checker.sv
tb/testbench.sv
